>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the centroid inner-product block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

>>> src/vcip_pkg.sv
// ----------------------------------------------------------------------------
// vcip_pkg
// Fixed widths, codes and shared types of the centroid inner-product block.
// ----------------------------------------------------------------------------
`default_nettype none

package vcip_pkg;

   localparam int ELEM_W     = 16;
   localparam int PROD_W     = 32;
   localparam int SUM_W      = 40;
   localparam int TAG_W      = 16;
   localparam int SEL_W      = 4;
   localparam int IDX_W      = 7;
   localparam int CIDX_W     = 4;
   localparam int NUM_W      = 5;
   localparam int DIM_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // request opcodes
   localparam logic OP_CENTROID = 1'b0;
   localparam logic OP_DATA     = 1'b1;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CENTROIDS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VEC_DIM       = 2'd1;

   localparam logic [NUM_W-1:0] NUM_CENTROIDS_RST = 5'd16;
   localparam logic [DIM_W-1:0] VEC_DIM_RST       = 8'd128;

   // one slot of the centroid sweep
   typedef struct packed {
      logic valid;
      logic last;
   } issue_type;

endpackage

`default_nettype wire

>>> src/vcip_ram.sv
// ----------------------------------------------------------------------------
// vcip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vcip_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> src/vcip_seq.sv
// ----------------------------------------------------------------------------
// vcip_seq
// Sweep sequencer: steps the shared multiply-accumulate over the centroids.
// ----------------------------------------------------------------------------
`default_nettype none

module vcip_seq #(
   parameter  int MAX_CENTROIDS = 16,
   parameter  int MAX_DIM       = 128,
   localparam int JW            = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1,
   localparam int CS_DEPTH      = MAX_CENTROIDS * MAX_DIM,
   localparam int CS_AW         = (CS_DEPTH > 1) ? $clog2(CS_DEPTH) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start_i,
   input  wire logic [CS_AW-1:0]    base_i,
   input  wire logic [JW-1:0]       last_cnum_i,
   output vcip_pkg::issue_type      issue_o,
   output logic      [JW-1:0]       cnum_o,
   output logic      [CS_AW-1:0]    addr_o,
   output logic                     busy_o
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type         state_ff;
   logic [JW-1:0]     cnum_ff;
   logic [JW-1:0]     last_ff;
   logic [CS_AW-1:0]  addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start_i) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (cnum_ff == last_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      // load while idle, advance one centroid row per cycle while running
      if (state_ff == ST_IDLE) begin
         cnum_ff <= '0;
         addr_ff <= base_i;
         last_ff <= last_cnum_i;
      end else begin
         cnum_ff <= cnum_ff + JW'(1);
         addr_ff <= addr_ff + CS_AW'(MAX_DIM);
      end
   end

   assign busy_o        = (state_ff == ST_RUN);
   assign issue_o.valid = (state_ff == ST_RUN);
   assign issue_o.last  = (cnum_ff == last_ff);
   assign cnum_o        = cnum_ff;
   assign addr_o        = addr_ff;

endmodule

`default_nettype wire

>>> src/vcip_mac.sv
// ----------------------------------------------------------------------------
// vcip_mac
// Shared multiply-accumulate with the partial sum store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vcip_mac #(
   parameter  int MAX_CENTROIDS = 16,
   localparam int JW            = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire vcip_pkg::issue_type                 issue_i,
   input  wire logic        [JW-1:0]                cnum_i,
   input  wire logic signed [vcip_pkg::ELEM_W-1:0]  cdata_i,
   input  wire logic signed [vcip_pkg::ELEM_W-1:0]  val_i,
   input  wire logic        [vcip_pkg::TAG_W-1:0]   tag_i,
   input  wire logic                                restart_i,
   input  wire logic                                emit_i,
   output logic                                     busy_o,
   output logic                                     rsp_valid_o,
   output logic             [vcip_pkg::TAG_W-1:0]   rsp_point_tag_o,
   output logic             [vcip_pkg::CIDX_W-1:0]  rsp_centroid_index_o,
   output logic signed      [vcip_pkg::SUM_W-1:0]   rsp_dot_sum_o,
   output logic                                     rsp_last_o
);

   vcip_pkg::issue_type                   s1_ff;
   vcip_pkg::issue_type                   s2_ff;
   logic        [JW-1:0]                  s1_cnum_ff;
   logic        [JW-1:0]                  s2_cnum_ff;
   logic signed [vcip_pkg::PROD_W-1:0]    prod_ff;
   logic        [MAX_CENTROIDS-1:0]       psum_valid_ff;
   logic        [vcip_pkg::SUM_W-1:0]     psum_rd;
   logic        [vcip_pkg::SUM_W-1:0]     prod_ext;
   logic        [vcip_pkg::SUM_W-1:0]     sum_in;

   vcip_ram #(
      .WIDTH (vcip_pkg::SUM_W),
      .DEPTH (MAX_CENTROIDS)
   ) u_psum_ram (
      .clock   (clock),
      .wr_en   (s2_ff.valid),
      .wr_addr (s2_cnum_ff),
      .wr_data (sum_in),
      .rd_en   (s1_ff.valid),
      .rd_addr (s1_cnum_ff),
      .rd_data (psum_rd)
   );

   // restart on index zero, and on an entry never written since reset
   assign prod_ext = {{(vcip_pkg::SUM_W - vcip_pkg::PROD_W){prod_ff[vcip_pkg::PROD_W-1]}},
                      prod_ff};
   assign sum_in   = (restart_i || !psum_valid_ff[s2_cnum_ff]) ? prod_ext
                                                                : psum_rd + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff         <= '0;
         s2_ff         <= '0;
         psum_valid_ff <= '0;
         rsp_valid_o   <= 1'b0;
      end else begin
         s1_ff       <= issue_i;
         s2_ff       <= s1_ff;
         rsp_valid_o <= s2_ff.valid && emit_i;
         if (s2_ff.valid) begin
            psum_valid_ff[s2_cnum_ff] <= 1'b1;
         end
      end
      s1_cnum_ff <= cnum_i;
      s2_cnum_ff <= s1_cnum_ff;
      prod_ff    <= val_i * cdata_i;
      if (s2_ff.valid) begin
         rsp_point_tag_o      <= tag_i;
         rsp_centroid_index_o <= vcip_pkg::CIDX_W'(s2_cnum_ff);
         rsp_dot_sum_o        <= sum_in;
         rsp_last_o           <= s2_ff.last;
      end
   end

   assign busy_o = s1_ff.valid || s2_ff.valid;

endmodule

`default_nettype wire

>>> src/vector_centroid_inner_products_core.sv
// ----------------------------------------------------------------------------
// vector_centroid_inner_products_core
// Inner products of streamed data vectors with a bank of stored centroids.
// ----------------------------------------------------------------------------
// Requests: a centroid write request never raises busy; a data request holds
//   busy while one shared multiply-accumulate visits each active centroid in
//   turn, and until the pipeline stages behind it drain. Results of a sweep
//   leave in centroid order; the receiver cannot stall.
// Reset: synchronous; num_centroids 16, vec_dim 128, sums zero, store kept.
`default_nettype none
`include "assert_macros.svh"

module vector_centroid_inner_products_core #(
   parameter int MAX_CENTROIDS = 16,
   parameter int MAX_DIM       = 128
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic                                  req_op,
   input  wire logic        [vcip_pkg::SEL_W-1:0]     req_centroid_sel,
   input  wire logic        [vcip_pkg::IDX_W-1:0]     req_elem_index,
   input  wire logic signed [vcip_pkg::ELEM_W-1:0]    req_elem_value,
   input  wire logic        [vcip_pkg::TAG_W-1:0]     req_point_id,
   // result channel
   output logic                                       rsp_valid,
   output logic             [vcip_pkg::TAG_W-1:0]     rsp_point_tag,
   output logic             [vcip_pkg::CIDX_W-1:0]    rsp_centroid_index,
   output logic signed      [vcip_pkg::SUM_W-1:0]     rsp_dot_sum,
   output logic                                       rsp_last,
   // register write channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic        [vcip_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [vcip_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int JW       = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
   localparam int CS_DEPTH = MAX_CENTROIDS * MAX_DIM;
   localparam int CS_AW    = (CS_DEPTH > 1) ? $clog2(CS_DEPTH) : 1;

   // configuration registers
   logic [vcip_pkg::NUM_W-1:0]        num_centroids_ff;
   logic [vcip_pkg::DIM_W-1:0]        vec_dim_ff;

   // current data request, held for the whole sweep
   logic signed [vcip_pkg::ELEM_W-1:0] val_ff;
   logic [vcip_pkg::TAG_W-1:0]         tag_ff;
   logic                               restart_ff;
   logic                               emit_ff;

   logic                      idx_ok;
   logic                      is_emit;
   logic                      sel_ok;
   logic [JW-1:0]             nc_last;
   logic [CS_AW-1:0]          cw_addr;
   logic                      req_accept;
   logic                      data_accept;
   logic                      cw_accept;

   vcip_pkg::issue_type       issue;
   logic [JW-1:0]             issue_cnum;
   logic [CS_AW-1:0]          issue_addr;
   logic                      seq_busy;
   logic                      mac_busy;
   logic signed [vcip_pkg::ELEM_W-1:0] cdata;

   // Clamp the registers to their working ranges: zero acts as one, and
   // anything above the build limits acts as the limit.
   always_comb begin
      int nc_eff;
      int dim_eff;
      int idx;
      nc_eff  = int'(num_centroids_ff);
      dim_eff = int'(vec_dim_ff);
      idx     = int'(req_elem_index);
      if (nc_eff == 0) begin
         nc_eff = 1;
      end
      if (nc_eff > MAX_CENTROIDS) begin
         nc_eff = MAX_CENTROIDS;
      end
      if (dim_eff == 0) begin
         dim_eff = 1;
      end
      if (dim_eff > MAX_DIM) begin
         dim_eff = MAX_DIM;
      end
      nc_last = JW'(nc_eff - 1);
      idx_ok  = (idx < dim_eff);
      is_emit = (idx == dim_eff - 1);
      sel_ok  = (int'(req_centroid_sel) < MAX_CENTROIDS);
      cw_addr = CS_AW'(int'(req_centroid_sel) * MAX_DIM + idx);
   end

   // Drop requests whose element index lies beyond the vector; drop centroid
   // writes that name a centroid beyond the store.
   assign req_accept  = start && !busy;
   assign data_accept = req_accept && idx_ok && (req_op == vcip_pkg::OP_DATA);
   assign cw_accept   = req_accept && idx_ok && sel_ok && (req_op == vcip_pkg::OP_CENTROID);

   // register writes land at once; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         num_centroids_ff <= vcip_pkg::NUM_CENTROIDS_RST;
         vec_dim_ff       <= vcip_pkg::VEC_DIM_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            vcip_pkg::CSR_NUM_CENTROIDS: begin
               num_centroids_ff <= csr_data[vcip_pkg::NUM_W-1:0];
            end
            vcip_pkg::CSR_VEC_DIM: begin
               vec_dim_ff <= csr_data[vcip_pkg::DIM_W-1:0];
            end
            default: begin
               num_centroids_ff <= num_centroids_ff;
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // hold the data request for the sweep
   always_ff @(posedge clock) begin
      if (data_accept) begin
         val_ff     <= req_elem_value;
         tag_ff     <= req_point_id;
         restart_ff <= (req_elem_index == '0);
         emit_ff    <= is_emit;
      end
   end

   // centroid store, row-major by centroid then element
   vcip_ram #(
      .WIDTH (vcip_pkg::ELEM_W),
      .DEPTH (CS_DEPTH)
   ) u_centroid_ram (
      .clock   (clock),
      .wr_en   (cw_accept),
      .wr_addr (cw_addr),
      .wr_data (req_elem_value),
      .rd_en   (issue.valid),
      .rd_addr (issue_addr),
      .rd_data (cdata)
   );

   vcip_seq #(
      .MAX_CENTROIDS (MAX_CENTROIDS),
      .MAX_DIM       (MAX_DIM)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start_i     (data_accept),
      .base_i      (CS_AW'(req_elem_index)),
      .last_cnum_i (nc_last),
      .issue_o     (issue),
      .cnum_o      (issue_cnum),
      .addr_o      (issue_addr),
      .busy_o      (seq_busy)
   );

   vcip_mac #(
      .MAX_CENTROIDS (MAX_CENTROIDS)
   ) u_mac (
      .clock                (clock),
      .reset                (reset),
      .issue_i              (issue),
      .cnum_i               (issue_cnum),
      .cdata_i              (cdata),
      .val_i                (val_ff),
      .tag_i                (tag_ff),
      .restart_i            (restart_ff),
      .emit_i               (emit_ff),
      .busy_o               (mac_busy),
      .rsp_valid_o          (rsp_valid),
      .rsp_point_tag_o      (rsp_point_tag),
      .rsp_centroid_index_o (rsp_centroid_index),
      .rsp_dot_sum_o        (rsp_dot_sum),
      .rsp_last_o           (rsp_last)
   );

   // busy spans the sweep and the two pipeline stages behind it
   assign busy = seq_busy || mac_busy;

   // a result only leaves the pipeline right behind a busy cycle
   `ASSERT_IMPLIES(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   // an accepted data request always starts a sweep
   `ASSERT_NEXT(a_data_starts_sweep, clock, reset, data_accept, busy)
   // the last result closes its burst
   `ASSERT_NEXT(a_last_closes_burst, clock, reset, rsp_valid && rsp_last, !rsp_valid)

endmodule

`default_nettype wire

>>> tb/vector_centroid_inner_products_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_centroid_inner_products_core_tb
// Self-checking bench for the centroid inner-product core. It keeps a shadow
// copy of the centroid bank, the running sums and both size registers, and
// predicts every result strobe from each accepted request. It covers directed
// corners (reset sizes, register clamping, ignored indexes, restarts, out of
// order elements) and a long randomized phase with random sender gaps.
// ----------------------------------------------------------------------------
module vector_centroid_inner_products_core_tb;
   import vcip_pkg::*;

   localparam int NCENT            = 16;
   localparam int NDIM             = 128;
   localparam int SETTLE_CYCLES    = 24;    // drain time for a full burst of 16 strobes
   localparam int STALL_LIMIT      = 2000;  // cycles with no handshake at all
   localparam int RANDOM_PHASE_END = 220;   // requests sent when the random phase stops
   localparam int SMALL_DIM        = 8;     // whole vectors only up to this size

   // register indexes with nothing behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      logic [TAG_W-1:0]  tag;
      logic [CIDX_W-1:0] centroid;
      logic [SUM_W-1:0]  product;
      logic              last;
   } product_type;

   // ------------------------------------------------------------------------
   // DUT signals
   // ------------------------------------------------------------------------
   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_op;
   logic [SEL_W-1:0]         req_centroid_sel;
   logic [IDX_W-1:0]         req_elem_index;
   logic signed [ELEM_W-1:0] req_elem_value;
   logic [TAG_W-1:0]         req_point_id;
   logic                     rsp_valid;
   logic [TAG_W-1:0]         rsp_point_tag;
   logic [CIDX_W-1:0]        rsp_centroid_index;
   logic signed [SUM_W-1:0]  rsp_dot_sum;
   logic                     rsp_last;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_data;

   // ------------------------------------------------------------------------
   // Shadow state of the block
   // ------------------------------------------------------------------------
   logic signed [ELEM_W-1:0] bank        [NCENT][NDIM];
   bit                       loaded      [NCENT][NDIM];
   logic [SUM_W-1:0]         running_sum [NCENT];
   logic [NUM_W-1:0]         num_reg;
   logic [DIM_W-1:0]         dim_reg;
   product_type              pending_products [$];
   product_type              want_product;

   int error_count;
   int data_used;        // data requests that reached the sums
   int writes_accepted;
   int reqs_sent;        // every request taken by the block
   int results_checked;
   int csr_writes;
   int idle_cycles;
   bit gaps_on;

   vector_centroid_inner_products_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_centroid_sel   (req_centroid_sel),
      .req_elem_index     (req_elem_index),
      .req_elem_value     (req_elem_value),
      .req_point_id       (req_point_id),
      .rsp_valid          (rsp_valid),
      .rsp_point_tag      (rsp_point_tag),
      .rsp_centroid_index (rsp_centroid_index),
      .rsp_dot_sum        (rsp_dot_sum),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   // Clamp the raw registers the way the block does: zero acts as one, and
   // anything above the bank size acts as the bank size.
   function automatic int active_centroids();
      int n;
      n = num_reg;
      if (n == 0) n = 1;
      if (n > NCENT) n = NCENT;
      return n;
   endfunction

   function automatic int active_dim();
      int d;
      d = dim_reg;
      if (d == 0) d = 1;
      if (d > NDIM) d = NDIM;
      return d;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] index,
                                          logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_NUM_CENTROIDS: num_reg = data[NUM_W-1:0];
         CSR_VEC_DIM:       dim_reg = data[DIM_W-1:0];
         default: ;  // spare index: drop the write
      endcase
   endfunction

   // Advance the shadow state by one accepted request and queue the results
   // it completes.
   function automatic void apply_request(logic op, logic [SEL_W-1:0] sel,
                                         logic [IDX_W-1:0] idx,
                                         logic signed [ELEM_W-1:0] val,
                                         logic [TAG_W-1:0] tag);
      int                       nc;
      int                       dim;
      logic signed [PROD_W-1:0] prod;
      logic [SUM_W-1:0]         prod_ext;
      product_type              item;
      nc  = active_centroids();
      dim = active_dim();
      if (int'(idx) >= dim) return;
      if (op == OP_CENTROID) begin
         bank[sel][idx]   = val;
         loaded[sel][idx] = 1'b1;
         return;
      end
      data_used++;
      for (int j = 0; j < nc; j++) begin
         prod     = val * bank[j][idx];
         prod_ext = {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
         if (idx == 0) running_sum[j] = prod_ext;
         else running_sum[j] = running_sum[j] + prod_ext;
      end
      if (int'(idx) == dim - 1) begin
         for (int j = 0; j < nc; j++) begin
            item.tag      = tag;
            item.centroid = CIDX_W'(j);
            item.product  = running_sum[j];
            item.last     = (j == nc - 1);
            pending_products.push_back(item);
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result checking: every strobe is taken, the receiver has no back-pressure
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_checked++;
         if (pending_products.size() == 0) begin
            report_mismatch($sformatf("unexpected result tag %h centroid %0d",
                                      rsp_point_tag, rsp_centroid_index));
         end else begin
            want_product = pending_products.pop_front();
            if (rsp_point_tag !== want_product.tag)
               report_mismatch($sformatf("point_tag %h, want %h",
                                         rsp_point_tag, want_product.tag));
            if (rsp_centroid_index !== want_product.centroid)
               report_mismatch($sformatf("centroid_index %0d, want %0d",
                                         rsp_centroid_index, want_product.centroid));
            if (rsp_dot_sum !== want_product.product)
               report_mismatch($sformatf("dot_sum %h, want %h (centroid %0d)",
                                         rsp_dot_sum, want_product.product,
                                         want_product.centroid));
            if (rsp_last !== want_product.last)
               report_mismatch($sformatf("last %b, want %b (centroid %0d)",
                                         rsp_last, want_product.last,
                                         want_product.centroid));
         end
      end
   end

   // Watchdog: reset the count on any handshake, bail out when it runs dry.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TIMEOUT: no handshake for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, pending_products.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Drivers: change inputs on the falling edge, sample on the rising edge
   // ------------------------------------------------------------------------
   function automatic logic signed [ELEM_W-1:0] rand_elem();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   // Send one request. Hold start high across back-to-back requests; drop it
   // only for a random idle burst.
   task automatic send_request(input logic op, input logic [SEL_W-1:0] sel,
                               input logic [IDX_W-1:0] idx,
                               input logic signed [ELEM_W-1:0] val,
                               input logic [TAG_W-1:0] tag);
      int gap;
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 14);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      @(negedge clock);
      start            <= 1'b1;
      req_op           <= op;
      req_centroid_sel <= sel;
      req_elem_index   <= idx;
      req_elem_value   <= val;
      req_point_id     <= tag;
      do @(posedge clock); while (busy);
      apply_request(op, sel, idx, val, tag);
      reqs_sent++;
      if (op == OP_CENTROID) writes_accepted++;
   endtask

   // Make sure every active centroid holds a value at this index before a
   // data request reads it; the bank is never cleared.
   task automatic send_data(input logic [IDX_W-1:0] idx,
                            input logic signed [ELEM_W-1:0] val,
                            input logic [TAG_W-1:0] tag);
      if (int'(idx) < active_dim()) begin
         for (int j = 0; j < active_centroids(); j++) begin
            if (!loaded[j][idx])
               send_request(OP_CENTROID, SEL_W'(j), idx, rand_elem(), TAG_W'($urandom));
         end
      end
      send_request(OP_DATA, SEL_W'($urandom), idx, val, tag);
   endtask

   task automatic send_vector(input logic [TAG_W-1:0] tag);
      int dim;
      dim = active_dim();
      for (int i = 0; i < dim; i++)
         send_data(IDX_W'(i), rand_elem(), tag);
   endtask

   // Drain: drop start, wait for every queued result, then give requests
   // that produce nothing time to leave the pipe.
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(index, data);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] nc_data,
                            input logic [CSR_DATA_W-1:0] dim_data);
      settle();
      csr_write(CSR_NUM_CENTROIDS, nc_data);
      csr_write(CSR_VEC_DIM, dim_data);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset sizes: 16 centroids and 128 elements, so index 127 closes the
   // vector. Use the most negative and most positive values on both sides.
   task automatic test_reset_sizes();
      for (int j = 0; j < NCENT; j++) begin
         send_request(OP_CENTROID, SEL_W'(j), 7'd0, 16'h8000, 16'h0000);
         send_request(OP_CENTROID, SEL_W'(j), 7'd127,
                      (j % 2 == 1) ? 16'h7FFF : 16'h8000, 16'hFFFF);
      end
      send_data(7'd0, 16'h8000, 16'h0000);
      send_data(7'd127, 16'h7FFF, 16'hFFFF);
   endtask

   // Register clamping and the spare register indexes.
   task automatic test_register_limits();
      // zero acts as one: single-element vectors against centroid 0 only
      configure(8'h00, 8'h00);
      send_data(7'd0, 16'h7FFF, 16'h1234);
      send_data(7'd1, 16'h1111, 16'h4321);                     // beyond dim: dropped
      send_request(OP_CENTROID, 4'd5, 7'd1, 16'h5555, 16'h0);  // beyond dim: dropped
      send_data(7'd0, 16'h8000, 16'hA5A5);
      // all ones: 31 centroids and 255 elements clamp to 16 and 128
      configure(8'hFF, 8'hFF);
      send_data(7'd127, 16'h8001, 16'h00FF);
      // spare indexes must leave both sizes alone
      settle();
      csr_write(CSR_SPARE_2, 8'h01);
      csr_write(CSR_SPARE_3, 8'hFF);
      send_data(7'd127, 16'h0001, 16'hFF00);
   endtask

   // Ignored indexes, restart at index zero, out of order elements and a
   // size change in the middle of a vector.
   task automatic test_index_handling();
      configure(8'd3, 8'd4);
      send_request(OP_CENTROID, 4'd2, 7'd4, 16'h7FFF, 16'h0);
      send_request(OP_CENTROID, 4'd9, 7'd127, 16'h8000, 16'h0);
      send_data(7'd6, 16'h7FFF, 16'h0BAD);
      send_data(7'd127, 16'h8000, 16'h0BAD);
      // partial vector, then a restart at zero
      send_data(7'd0, 16'h7FFF, 16'h0001);
      send_data(7'd1, 16'h7FFF, 16'h0001);
      send_vector(16'h0002);
      // no ordering check: the last index emits whenever it shows up
      send_data(7'd3, rand_elem(), 16'h0003);
      send_data(7'd1, rand_elem(), 16'h0004);
      send_data(7'd0, rand_elem(), 16'h0005);
      send_data(7'd2, rand_elem(), 16'h0006);
      send_data(7'd3, rand_elem(), 16'h0007);
      // widen the centroid set halfway through a vector
      send_data(7'd0, rand_elem(), 16'h0008);
      send_data(7'd1, rand_elem(), 16'h0008);
      configure(8'd5, 8'd4);
      send_data(7'd2, rand_elem(), 16'h0008);
      send_data(7'd3, rand_elem(), 16'h0008);
      // single-element vectors: index zero restarts and emits at once
      configure(8'd5, 8'd1);
      send_data(7'd0, 16'h8000, 16'h0009);
      send_data(7'd0, 16'h7FFF, 16'h000A);
   endtask

   task automatic pick_config();
      logic [CSR_DATA_W-1:0] nc_data;
      logic [CSR_DATA_W-1:0] dim_data;
      nc_data = CSR_DATA_W'($urandom);  // upper bits are don't-care
      case ($urandom_range(0, 9))
         0:       nc_data[NUM_W-1:0] = '0;
         1:       nc_data[NUM_W-1:0] = NUM_W'($urandom_range(17, 31));
         default: nc_data[NUM_W-1:0] = NUM_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 39))
         0:       dim_data = 8'd0;
         1:       dim_data = 8'd128;
         2:       dim_data = CSR_DATA_W'($urandom_range(129, 255));
         3, 4:    dim_data = 8'd1;
         5:       dim_data = CSR_DATA_W'($urandom_range(9, 24));
         default: dim_data = CSR_DATA_W'($urandom_range(2, 8));
      endcase
      configure(nc_data, dim_data);
   endtask

   // Mostly whole vectors with random content, plus broken sequences,
   // centroid overwrites and out-of-range noise. Large sizes get only a few
   // scattered elements, closing the vector at its last index.
   task automatic test_random_traffic();
      int  n;
      int  hi;
      bit  was_big;
      was_big = 1'b0;
      while (reqs_sent < RANDOM_PHASE_END) begin
         // leave a large size after one action so most traffic stays small
         if (was_big || $urandom_range(0, 3) == 0) pick_config();
         gaps_on = ($urandom_range(0, 3) != 0);
         was_big = (active_dim() > SMALL_DIM);
         case ($urandom_range(0, 9))
            7: begin
               n  = was_big ? $urandom_range(1, 2) : $urandom_range(1, 8);
               hi = (active_dim() < NDIM) ? active_dim() : NDIM - 1;
               repeat (n)
                  send_data(IDX_W'($urandom_range(0, hi)), rand_elem(),
                            TAG_W'($urandom));
            end
            8: begin
               repeat ($urandom_range(1, 4))
                  send_request(OP_CENTROID, SEL_W'($urandom),
                               IDX_W'($urandom_range(0, active_dim() - 1)),
                               rand_elem(), TAG_W'($urandom));
            end
            9: begin
               if (active_dim() < NDIM) begin
                  send_data(IDX_W'($urandom_range(active_dim(), NDIM - 1)),
                            rand_elem(), TAG_W'($urandom));
                  send_request(OP_CENTROID, SEL_W'($urandom),
                               IDX_W'($urandom_range(active_dim(), NDIM - 1)),
                               rand_elem(), TAG_W'($urandom));
               end
            end
            default: begin
               if (was_big)
                  send_data(IDX_W'(active_dim() - 1), rand_elem(), TAG_W'($urandom));
               else
                  send_vector(TAG_W'($urandom));
            end
         endcase
      end
      gaps_on = 1'b1;
   endtask

   // Final stretch with start held high: requests queue right behind busy.
   task automatic test_back_to_back();
      gaps_on = 1'b0;
      configure(8'd16, 8'd3);
      repeat (3) send_vector(TAG_W'($urandom));
      configure(8'd1, 8'd2);
      repeat (3) send_vector(TAG_W'($urandom));
      configure(CSR_DATA_W'($urandom_range(1, 16)), CSR_DATA_W'($urandom_range(1, 6)));
      repeat (3) send_vector(TAG_W'($urandom));
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      // hold every input at a known value from time zero
      reset            = 1'b1;
      start            = 1'b0;
      req_op           = OP_CENTROID;
      req_centroid_sel = '0;
      req_elem_index   = '0;
      req_elem_value   = '0;
      req_point_id     = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_NUM_CENTROIDS;
      csr_data         = '0;

      error_count     = 0;
      data_used       = 0;
      writes_accepted = 0;
      reqs_sent       = 0;
      results_checked = 0;
      csr_writes      = 0;
      gaps_on         = 1'b1;
      num_reg         = NUM_CENTROIDS_RST;
      dim_reg         = VEC_DIM_RST;
      for (int j = 0; j < NCENT; j++) begin
         running_sum[j] = '0;
         for (int i = 0; i < NDIM; i++) begin
            loaded[j][i] = 1'b0;
            bank[j][i]   = '0;
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_sizes();
      test_register_limits();
      test_index_handling();
      test_random_traffic();
      test_back_to_back();
      settle();

      $display("Run covered %0d requests: %0d data into the sums, %0d centroid writes",
               reqs_sent, data_used, writes_accepted);
      $display("and %0d register writes; %0d result strobes checked, %0d mismatches",
               csr_writes, results_checked, error_count);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
